/* sv/vertex_dedup_indexer_assert.svh */
// ---------------------------------------------------------------------------
// vertex_dedup_indexer assertion macros
// concurrent checks on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef VERTEX_DEDUP_INDEXER_ASSERT_SVH
`define VERTEX_DEDUP_INDEXER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VDI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define VDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/vdi_pkg.sv */
// ---------------------------------------------------------------------------
// vdi_pkg
// shared constants and types for the vertex deduplication indexer
// ---------------------------------------------------------------------------
`default_nettype none

package vdi_pkg;

  localparam int MAX_CORNERS      = 1024;
  localparam int WORDS_PER_CORNER = 8;
  localparam int WORD_W           = 32;
  localparam int CORNER_W         = WORDS_PER_CORNER * WORD_W;
  localparam int IDX_W            = $clog2(MAX_CORNERS);
  localparam int CNT_W            = $clog2(MAX_CORNERS + 1);
  localparam int OUT_IDX_W        = 10;

  typedef logic [CORNER_W-1:0] corner_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    addr_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic  key_load;
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
  } mem_req_t;

  typedef struct packed {
    logic                 done;
    logic [OUT_IDX_W-1:0] index;
    logic                 found;
    logic                 ovf;
  } result_t;

endpackage

`default_nettype wire

/* sv/vdi_ram.sv */
// ---------------------------------------------------------------------------
// vdi_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module vdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/vdi_cmp.sv */
// ---------------------------------------------------------------------------
// vdi_cmp
// holds the search key and compares it bitwise with one stored corner
// ---------------------------------------------------------------------------
`default_nettype none

module vdi_cmp (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire vdi_pkg::corner_t key_in,
  input  wire vdi_pkg::corner_t entry,
  output      vdi_pkg::corner_t key,
  output      logic            match
);
  import vdi_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      key <= key_in;
    end
  end

  assign match = (entry == key);

endmodule

`default_nettype wire

/* sv/vdi_ctrl.sv */
// ---------------------------------------------------------------------------
// vdi_ctrl
// search sequencer: walks the stored corners, reports a match, else appends or flags overflow
// ---------------------------------------------------------------------------
`default_nettype none

module vdi_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             first_corner,
  input  wire logic             match,
  output      logic             busy,
  output      vdi_pkg::mem_req_t req,
  output      vdi_pkg::result_t  res
);
  import vdi_pkg::*;

  localparam cnt_t FULL = CNT_W'(MAX_CORNERS);

  state_t  state, state_next;
  cnt_t    count, count_next;
  cnt_t    ptr, ptr_next;
  logic    inflight, inflight_next;
  cnt_t    inflight_idx, inflight_idx_next;
  result_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      inflight <= 1'b0;
      res.done <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      inflight <= inflight_next;
      res.done <= res_next.done;
    end
    ptr          <= ptr_next;
    inflight_idx <= inflight_idx_next;
    res.index    <= res_next.index;
    res.found    <= res_next.found;
    res.ovf      <= res_next.ovf;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    ptr_next          = ptr;
    inflight_next     = inflight;
    inflight_idx_next = inflight_idx;
    req               = '0;
    res_next          = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          count_next    = first_corner ? '0 : count;
          ptr_next      = '0;
          inflight_next = 1'b0;
          req.key_load  = 1'b1;
          state_next    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (ptr < count) begin
          req.rd_en         = 1'b1;
          req.rd_addr       = ptr[IDX_W-1:0];
          ptr_next          = ptr + CNT_W'(1);
          inflight_next     = 1'b1;
          inflight_idx_next = ptr;
        end else begin
          inflight_next = 1'b0;
        end
        if (inflight && match) begin
          res_next.done  = 1'b1;
          res_next.found = 1'b1;
          res_next.index = OUT_IDX_W'(inflight_idx);
          state_next     = ST_IDLE;
        end else if (!inflight && (ptr >= count)) begin
          res_next.done = 1'b1;
          if (count == FULL) begin
            res_next.ovf = 1'b1;
          end else begin
            req.wr_en      = 1'b1;
            req.wr_addr    = count[IDX_W-1:0];
            res_next.index = OUT_IDX_W'(count);
            count_next     = count + CNT_W'(1);
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

/* sv/vertex_dedup_indexer.sv */
// done rises once entry i has been read and compared when entry i matches, and once every
// stored corner has been read and compared when nothing matches; done and the result are registered
// start is not taken while busy, so a search ends before the next begins; it compares one entry per
// cycle over the corner ram read port; start is taken again in the cycle done is high
// reset: synchronous rst empties the table and returns to idle; ram contents are not cleared
// results are never stalled: each is shown for exactly one cycle with done
// ---------------------------------------------------------------------------
// vertex_dedup_indexer
// builds an indexed vertex buffer, or flags overflow when full: returns the index of the first identical
// stored corner or appends the corner as a new unique entry
// ---------------------------------------------------------------------------
`default_nettype none

`include "vertex_dedup_indexer_assert.svh"

module vertex_dedup_indexer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        first_corner,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [31:0] norm_x,
  input  wire logic [31:0] norm_y,
  input  wire logic [31:0] norm_z,
  input  wire logic [31:0] tex_u,
  input  wire logic [31:0] tex_v,
  output      logic        done,
  output      logic [9:0]  corner_index,
  output      logic        was_found,
  output      logic        overflow
);
  import vdi_pkg::*;

  corner_t  key_in;
  corner_t  key;
  corner_t  entry;
  logic     match;
  mem_req_t req;
  result_t  res;

  assign key_in = {pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v};

  vdi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .first_corner (first_corner),
    .match        (match),
    .busy         (busy),
    .req          (req),
    .res          (res)
  );

  vdi_cmp u_cmp (
    .clk    (clk),
    .load   (req.key_load),
    .key_in (key_in),
    .entry  (entry),
    .key    (key),
    .match  (match)
  );

  vdi_ram #(
    .WIDTH (CORNER_W),
    .DEPTH (MAX_CORNERS)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_addr),
    .wdata (key),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (entry)
  );

  assign done         = res.done;
  assign corner_index = res.index;
  assign was_found    = res.found;
  assign overflow     = res.ovf;

  `VDI_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done, "accepted transaction not busy")
  `VDI_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still searching")
  `VDI_ASSERT_NOW(a_flags_excl, done, !(was_found && overflow), "match and overflow together")
  `VDI_ASSERT_NOW(a_ovf_index, done && overflow, corner_index == '0, "overflow with nonzero index")
  `VDI_ASSERT_NEXT(a_no_rw_clash, req.wr_en, !busy, "table written mid search")

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ---------------------------------------------------------------------------
// vertex_dedup_indexer testbench
// drives triangle corners through the start/busy handshake and checks each
// returned index, found flag and overflow flag against a behavioural table of
// unique corners kept in the bench; covers reset state, bitwise compare of
// signed zeros and nan patterns, mesh restart, a completely full table and
// long runs of random meshes with repeated and slightly altered corners
// ---------------------------------------------------------------------------
module testbench;

  import vdi_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;

  typedef logic [WORDS_PER_CORNER-1:0][WORD_W-1:0] vertex_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic                 found;
    logic                 ovf;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        first_corner = 1'b0;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_y = '0;
  logic [31:0] pos_z = '0;
  logic [31:0] norm_x = '0;
  logic [31:0] norm_y = '0;
  logic [31:0] norm_z = '0;
  logic [31:0] tex_u = '0;
  logic [31:0] tex_v = '0;
  logic        done;
  logic [9:0]  corner_index;
  logic        was_found;
  logic        overflow;

  vertex_t mesh_table [MAX_CORNERS];
  int      mesh_count = 0;
  lookup_t pending_lookups [$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      idle_pct = 0;

  vertex_dedup_indexer dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .first_corner (first_corner),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .norm_x       (norm_x),
    .norm_y       (norm_y),
    .norm_z       (norm_z),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .done         (done),
    .corner_index (corner_index),
    .was_found    (was_found),
    .overflow     (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic lookup_t lookup_corner(input logic first, input vertex_t v);
    lookup_t r;
    int      hit;
    r = '0;
    hit = -1;
    if (first) mesh_count = 0;
    for (int i = 0; i < mesh_count; i++) begin
      if (mesh_table[i] == v) begin
        hit = i;
        break;
      end
    end
    if (hit >= 0) begin
      r.index = hit[OUT_IDX_W-1:0];
      r.found = 1'b1;
    end else if (mesh_count >= MAX_CORNERS) begin
      r.ovf = 1'b1;
    end else begin
      mesh_table[mesh_count] = v;
      r.index = mesh_count[OUT_IDX_W-1:0];
      mesh_count++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // entered just after a rising edge; returns at the edge that takes the transaction
  task automatic send_corner(input logic first, input vertex_t v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    first_corner <= first;
    pos_x        <= v[0];
    pos_y        <= v[1];
    pos_z        <= v[2];
    norm_x       <= v[3];
    norm_y       <= v[4];
    norm_z       <= v[5];
    tex_u        <= v[6];
    tex_v        <= v[7];
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_lookups.push_back(lookup_corner(first, v));
  endtask

  always @(negedge clk) begin
    lookup_t want;
    if (!rst && done) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected result, index %0d", corner_index));
      end else begin
        want = pending_lookups.pop_front();
        if (corner_index !== want.index)
          report_mismatch($sformatf("corner_index %0d, expected %0d", corner_index, want.index));
        if (was_found !== want.found)
          report_mismatch($sformatf("was_found %b, expected %b", was_found, want.found));
        if (overflow !== want.ovf)
          report_mismatch($sformatf("overflow %b, expected %b", overflow, want.ovf));
      end
    end
  end

  // no first-corner flag: the table must already be empty out of reset
  task automatic test_reset_state();
    send_corner(1'b0, '0);
    send_corner(1'b0, '1);
    send_corner(1'b0, '0);
    send_corner(1'b0, '1);
  endtask

  task automatic test_signed_zero_and_nan();
    vertex_t v;
    v = '0;
    v[0] = 32'h8000_0000;
    send_corner(1'b0, v);
    v = '0;
    v[3] = 32'h7FC0_0000;
    send_corner(1'b0, v);
    v[3] = 32'h7FC0_0001;
    send_corner(1'b0, v);
    v[3] = 32'h7FC0_0000;
    send_corner(1'b0, v);
  endtask

  task automatic test_each_word();
    vertex_t v;
    for (int w = 0; w < WORDS_PER_CORNER; w++) begin
      v = '0;
      v[w] = 32'h8000_0000;
      send_corner(1'b0, v);
    end
  endtask

  task automatic test_new_mesh();
    send_corner(1'b1, '1);
    send_corner(1'b0, '0);
    send_corner(1'b1, '1);
    send_corner(1'b1, '1);
  endtask

  // corner i carries i in word i mod 8, all other words ones
  task automatic test_table_full();
    vertex_t v;
    int      j;
    for (int i = 0; i < MAX_CORNERS; i++) begin
      v = '1;
      v[i % WORDS_PER_CORNER] = i;
      send_corner(i == 0, v);
      if (i % 128 == 127) begin
        j = i / 2;
        v = '1;
        v[j % WORDS_PER_CORNER] = j;
        send_corner(1'b0, v);
      end
    end
    send_corner(1'b0, '0);
    v = '1;
    v[(MAX_CORNERS - 1) % WORDS_PER_CORNER] = MAX_CORNERS - 1;
    send_corner(1'b0, v);
    v = '1;
    v[0] = 0;
    send_corner(1'b0, v);
    v = '1;
    v[5] = 5;
    v[2] = 32'h7FFF_FFFF;
    send_corner(1'b0, v);
    v = '1;
    v[5] = 5;
    send_corner(1'b0, v);
    send_corner(1'b1, '0);
  endtask

  // meshes of repeated corners, some altered by one bit, with the odd restart mid mesh
  task automatic test_random_meshes(input int n_items, input int pct);
    vertex_t pool [$];
    vertex_t v;
    int      left;
    int      pick;
    int      word_sel;
    int      bit_sel;
    logic    first;
    idle_pct = pct;
    left = 0;
    repeat (n_items) begin
      first = 1'b0;
      if (left == 0) begin
        left = $urandom_range(48, 1);
        pool.delete();
        first = 1'b1;
      end else if ($urandom_range(99) < 3) begin
        first = 1'b1;
      end
      pick = $urandom_range(99);
      if (pool.size() != 0 && pick < 70) begin
        v = pool[$urandom_range(pool.size() - 1)];
        if (pick >= 55) begin
          word_sel = $urandom_range(WORDS_PER_CORNER - 1);
          bit_sel = ($urandom_range(3) == 0) ? 31 : $urandom_range(31);
          v[word_sel][bit_sel] = ~v[word_sel][bit_sel];
        end
      end else begin
        foreach (v[w]) begin
          case ($urandom_range(7))
            0:       v[w] = 32'h0000_0000;
            1:       v[w] = 32'h8000_0000;
            default: v[w] = $urandom();
          endcase
        end
      end
      pool.push_back(v);
      send_corner(first, v);
      left--;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 26;
    test_reset_state();
    test_signed_zero_and_nan();
    test_each_word();
    test_new_mesh();
    test_table_full();
    test_random_meshes(190, 26);
    test_random_meshes(190, 70);
    test_random_meshes(200, 0);
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (MAX_CORNERS + 3) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
